[rtl/rvdec_pkg.sv]
`default_nettype none

package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned OpWidth    = 6;
  localparam int unsigned RegIdWidth = 5;
  localparam int unsigned ImmWidth   = 32;

  // Result beat: operation, dest, src1, src2, immediate; padded to whole bytes.
  localparam int unsigned ResultBits   = OpWidth + 3 * RegIdWidth + ImmWidth;
  localparam int unsigned ResultTWidth = ((ResultBits + 7) / 8) * 8;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic [6:0] F7_BASE  = 7'h00;
  localparam logic [6:0] F7_MEXT  = 7'h01;
  localparam logic [6:0] F7_ALT   = 7'h20;
  localparam logic [6:0] F7_SRET  = 7'h08;
  localparam logic [6:0] F7_SFENC = 7'h09;
  localparam logic [6:0] F7_MRET  = 7'h18;

  localparam logic [4:0] F5_ECALL  = 5'd0;
  localparam logic [4:0] F5_EBREAK = 5'd1;
  localparam logic [4:0] F5_RET    = 5'd2;
  localparam logic [4:0] F5_WFI    = 5'd5;

  localparam logic [4:0] SHIFT_HI_SRL = 5'd0;
  localparam logic [4:0] SHIFT_HI_SRA = 5'd8;

  localparam logic [OpWidth-1:0] OP_LUI     = 6'd0;
  localparam logic [OpWidth-1:0] OP_AUIPC   = 6'd1;
  localparam logic [OpWidth-1:0] OP_ADDI    = 6'd2;
  localparam logic [OpWidth-1:0] OP_SLTI    = 6'd3;
  localparam logic [OpWidth-1:0] OP_SLTIU   = 6'd4;
  localparam logic [OpWidth-1:0] OP_XORI    = 6'd5;
  localparam logic [OpWidth-1:0] OP_ORI     = 6'd6;
  localparam logic [OpWidth-1:0] OP_ANDI    = 6'd7;
  localparam logic [OpWidth-1:0] OP_SLLI    = 6'd8;
  localparam logic [OpWidth-1:0] OP_SRLI    = 6'd9;
  localparam logic [OpWidth-1:0] OP_SRAI    = 6'd10;
  localparam logic [OpWidth-1:0] OP_ADD     = 6'd11;
  localparam logic [OpWidth-1:0] OP_MUL     = 6'd12;
  localparam logic [OpWidth-1:0] OP_SUB     = 6'd13;
  localparam logic [OpWidth-1:0] OP_SLL     = 6'd14;
  localparam logic [OpWidth-1:0] OP_MULH    = 6'd15;
  localparam logic [OpWidth-1:0] OP_SLT     = 6'd16;
  localparam logic [OpWidth-1:0] OP_MULHSU  = 6'd17;
  localparam logic [OpWidth-1:0] OP_SLTU    = 6'd18;
  localparam logic [OpWidth-1:0] OP_MULHU   = 6'd19;
  localparam logic [OpWidth-1:0] OP_XOR     = 6'd20;
  localparam logic [OpWidth-1:0] OP_DIV     = 6'd21;
  localparam logic [OpWidth-1:0] OP_SRL     = 6'd22;
  localparam logic [OpWidth-1:0] OP_DIVU    = 6'd23;
  localparam logic [OpWidth-1:0] OP_SRA     = 6'd24;
  localparam logic [OpWidth-1:0] OP_OR      = 6'd25;
  localparam logic [OpWidth-1:0] OP_REM     = 6'd26;
  localparam logic [OpWidth-1:0] OP_AND     = 6'd27;
  localparam logic [OpWidth-1:0] OP_REMU    = 6'd28;
  localparam logic [OpWidth-1:0] OP_FENCE   = 6'd29;
  localparam logic [OpWidth-1:0] OP_FENCE_I = 6'd30;
  localparam logic [OpWidth-1:0] OP_ECALL   = 6'd31;
  localparam logic [OpWidth-1:0] OP_EBREAK  = 6'd32;
  localparam logic [OpWidth-1:0] OP_WFI     = 6'd33;
  localparam logic [OpWidth-1:0] OP_SFENCE  = 6'd34;
  localparam logic [OpWidth-1:0] OP_CSRRW   = 6'd35;
  localparam logic [OpWidth-1:0] OP_CSRRS   = 6'd36;
  localparam logic [OpWidth-1:0] OP_CSRRC   = 6'd37;
  localparam logic [OpWidth-1:0] OP_CSRRWI  = 6'd38;
  localparam logic [OpWidth-1:0] OP_CSRRSI  = 6'd39;
  localparam logic [OpWidth-1:0] OP_CSRRCI  = 6'd40;
  localparam logic [OpWidth-1:0] OP_LB      = 6'd41;
  localparam logic [OpWidth-1:0] OP_LH      = 6'd42;
  localparam logic [OpWidth-1:0] OP_LW      = 6'd43;
  localparam logic [OpWidth-1:0] OP_LBU     = 6'd44;
  localparam logic [OpWidth-1:0] OP_LHU     = 6'd45;
  localparam logic [OpWidth-1:0] OP_SB      = 6'd46;
  localparam logic [OpWidth-1:0] OP_SH      = 6'd47;
  localparam logic [OpWidth-1:0] OP_SW      = 6'd48;
  localparam logic [OpWidth-1:0] OP_JAL     = 6'd49;
  localparam logic [OpWidth-1:0] OP_JALR    = 6'd50;
  localparam logic [OpWidth-1:0] OP_BEQ     = 6'd51;
  localparam logic [OpWidth-1:0] OP_BNE     = 6'd52;
  localparam logic [OpWidth-1:0] OP_BLT     = 6'd53;
  localparam logic [OpWidth-1:0] OP_BGE     = 6'd54;
  localparam logic [OpWidth-1:0] OP_BLTU    = 6'd55;
  localparam logic [OpWidth-1:0] OP_BGEU    = 6'd56;
  localparam logic [OpWidth-1:0] OP_RETNOP  = 6'd57;

  typedef struct packed {
    logic [ImmWidth-1:0]   immediate;
    logic [RegIdWidth-1:0] src2_index;
    logic [RegIdWidth-1:0] src1_index;
    logic [RegIdWidth-1:0] dest_index;
    logic [OpWidth-1:0]    operation;
  } result_t;

endpackage

`default_nettype wire

[rtl/rv32im_instruction_decoder.sv]
`default_nettype none

// Decodes one RV32IM instruction word per beat into an operation number, the three register
// indices and the immediate of its format, sign-extended but zero-extended for CSR operations;
// illegal encodings raise tuser with operation and immediate forced to zero. A word is taken
// every cycle while the result side is not stalled; it is held in the input register, decoded,
// and its result is held in the result register, the two registers that frame the decode logic.
// Back-pressure on the result side stalls both stages in place.
module rv32im_instruction_decoder
  import rvdec_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0 up: instruction_word.
  input  wire logic [InstrWidth-1:0]   s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // Fields from bit 0 up: operation, dest_index, src1_index, src2_index, immediate, zero pad.
  output logic [ResultTWidth-1:0]      m_axis_tdata_o,
  // Fields from bit 0 up: illegal.
  output logic                         m_axis_tuser_o
);

  logic                  in_valid_q, in_valid_d;
  logic [InstrWidth-1:0] word_q;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;
  logic                  illegal_q, illegal_d;
  logic                  s_beat, out_free, advance;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  logic [6:0]          opc, f7;
  logic [2:0]          f3;
  logic [4:0]          f5;
  logic [ImmWidth-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_csr, imm;
  logic [OpWidth-1:0]  op;
  logic                legal;

  assign opc     = word_q[6:0];
  assign f3      = word_q[14:12];
  assign f5      = word_q[24:20];
  assign f7      = word_q[31:25];
  assign imm_i   = {{20{word_q[31]}}, word_q[31:20]};
  assign imm_s   = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
  assign imm_b   = {{19{word_q[31]}}, word_q[31], word_q[7], word_q[30:25], word_q[11:8], 1'b0};
  assign imm_u   = {word_q[31:12], 12'h000};
  assign imm_j   = {{11{word_q[31]}}, word_q[31], word_q[19:12], word_q[20], word_q[30:21],
                    1'b0};
  assign imm_csr = {20'h00000, word_q[31:20]};

  always_comb begin
    op    = OP_LUI;
    legal = 1'b1;
    imm   = '0;
    case (opc)
      OPC_LUI: begin
        op  = OP_LUI;
        imm = imm_u;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        imm = imm_u;
      end
      OPC_OPIMM: begin
        imm = imm_i;
        case (f3)
          3'd0: op = OP_ADDI;
          3'd1: op = OP_SLLI;
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: begin
            if (word_q[31:27] == SHIFT_HI_SRL) begin
              op = OP_SRLI;
            end else if (word_q[31:27] == SHIFT_HI_SRA) begin
              op = OP_SRAI;
            end else begin
              legal = 1'b0;
            end
          end
          3'd6: op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (f7 == F7_MEXT) begin
          case (f3)
            3'd0: op = OP_MUL;
            3'd1: op = OP_MULH;
            3'd2: op = OP_MULHSU;
            3'd3: op = OP_MULHU;
            3'd4: op = OP_DIV;
            3'd5: op = OP_DIVU;
            3'd6: op = OP_REM;
            default: op = OP_REMU;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          op = OP_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          op = OP_SRA;
        end else begin
          legal = 1'b0;
        end
      end
      OPC_FENCE: begin
        if (f3 == 3'd0) begin
          op = OP_FENCE;
        end else if (f3 == 3'd1) begin
          op = OP_FENCE_I;
        end else begin
          legal = 1'b0;
        end
      end
      OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (f7 == F7_BASE && f5 == F5_ECALL) begin
            op = OP_ECALL;
          end else if (f7 == F7_BASE && f5 == F5_EBREAK) begin
            op = OP_EBREAK;
          end else if ((f7 == F7_BASE || f7 == F7_SRET || f7 == F7_MRET) && f5 == F5_RET) begin
            op = OP_RETNOP;
          end else if (f7 == F7_SRET && f5 == F5_WFI) begin
            op = OP_WFI;
          end else if (f7 == F7_SFENC) begin
            op = OP_SFENCE;
          end else begin
            legal = 1'b0;
          end
        end else begin
          imm = imm_csr;
          case (f3)
            3'd1: op = OP_CSRRW;
            3'd2: op = OP_CSRRS;
            3'd3: op = OP_CSRRC;
            3'd5: op = OP_CSRRWI;
            3'd6: op = OP_CSRRSI;
            3'd7: op = OP_CSRRCI;
            default: legal = 1'b0;
          endcase
        end
      end
      OPC_LOAD: begin
        imm = imm_i;
        case (f3)
          3'd0: op = OP_LB;
          3'd1: op = OP_LH;
          3'd2: op = OP_LW;
          3'd4: op = OP_LBU;
          3'd5: op = OP_LHU;
          default: legal = 1'b0;
        endcase
      end
      OPC_STORE: begin
        imm = imm_s;
        case (f3)
          3'd0: op = OP_SB;
          3'd1: op = OP_SH;
          3'd2: op = OP_SW;
          default: legal = 1'b0;
        endcase
      end
      OPC_JAL: begin
        op  = OP_JAL;
        imm = imm_j;
      end
      OPC_JALR: begin
        op  = OP_JALR;
        imm = imm_i;
      end
      OPC_BRANCH: begin
        imm = imm_b;
        case (f3)
          3'd0: op = OP_BEQ;
          3'd1: op = OP_BNE;
          3'd4: op = OP_BLT;
          3'd5: op = OP_BGE;
          3'd6: op = OP_BLTU;
          3'd7: op = OP_BGEU;
          default: legal = 1'b0;
        endcase
      end
      default: legal = 1'b0;
    endcase
  end

  always_comb begin
    res_d.operation  = legal ? op : OP_LUI;
    res_d.immediate  = legal ? imm : '0;
    res_d.dest_index = word_q[11:7];
    res_d.src1_index = word_q[19:15];
    res_d.src2_index = word_q[24:20];
    illegal_d        = !legal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      word_q <= s_axis_tdata_i;
    end
    if (advance) begin
      res_q     <= res_d;
      illegal_q <= illegal_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(ResultTWidth - ResultBits){1'b0}}, res_q};
  assign m_axis_tuser_o  = illegal_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (res_q.operation == OP_LUI && res_q.immediate == '0))
    else $error("illegal beat carries a non-zero operation or immediate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_q.operation <= OP_RETNOP))
    else $error("operation number out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> m_axis_tvalid_o)
    else $error("decoded word did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

[bench/rv32im_instruction_decoder_tb.sv]
`timescale 1ns / 1ps

module rv32im_instruction_decoder_tb;
  import rvdec_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomWords = 450;
  localparam int unsigned PrintLimit = 60;

  localparam logic [OpWidth-1:0] OP_INVALID = 6'h3F;
  localparam logic [2:0]         F3_PRIV    = 3'd0;

  // Operation tables indexed by funct3, highest funct3 first.
  localparam logic [7:0][OpWidth-1:0] OPIMM_OPS = {OP_ANDI, OP_ORI, OP_SRLI, OP_XORI,
                                                   OP_SLTIU, OP_SLTI, OP_SLLI, OP_ADDI};
  localparam logic [7:0][OpWidth-1:0] BASE_OPS = {OP_AND, OP_OR, OP_SRL, OP_XOR,
                                                  OP_SLTU, OP_SLT, OP_SLL, OP_ADD};
  localparam logic [7:0][OpWidth-1:0] MEXT_OPS = {OP_REMU, OP_REM, OP_DIVU, OP_DIV,
                                                  OP_MULHU, OP_MULHSU, OP_MULH, OP_MUL};
  localparam logic [7:0][OpWidth-1:0] CSR_OPS = {OP_CSRRCI, OP_CSRRSI, OP_CSRRWI, OP_INVALID,
                                                 OP_CSRRC, OP_CSRRS, OP_CSRRW, OP_INVALID};
  localparam logic [7:0][OpWidth-1:0] LOAD_OPS = {OP_INVALID, OP_INVALID, OP_LHU, OP_LBU,
                                                  OP_INVALID, OP_LW, OP_LH, OP_LB};
  localparam logic [7:0][OpWidth-1:0] STORE_OPS = {OP_INVALID, OP_INVALID, OP_INVALID,
                                                   OP_INVALID, OP_INVALID, OP_SW, OP_SH, OP_SB};
  localparam logic [7:0][OpWidth-1:0] BRANCH_OPS = {OP_BGEU, OP_BLTU, OP_BGE, OP_BLT,
                                                    OP_INVALID, OP_INVALID, OP_BNE, OP_BEQ};
  localparam logic [7:0][OpWidth-1:0] FENCE_OPS = {OP_INVALID, OP_INVALID, OP_INVALID,
                                                   OP_INVALID, OP_INVALID, OP_INVALID,
                                                   OP_FENCE_I, OP_FENCE};

  typedef struct packed {
    logic [InstrWidth-1:0] word;
    logic                  illegal;
    result_t               fields;
  } decode_t;

  typedef struct {
    logic [InstrWidth-1:0] word;
    bit                    typed;
    logic                  illegal;
    logic [OpWidth-1:0]    operation;
    logic [ImmWidth-1:0]   immediate;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [InstrWidth-1:0]   s_axis_tdata_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [ResultTWidth-1:0] m_axis_tdata_o;
  logic                    m_axis_tuser_o;

  decode_t         pending_decodes[$];
  stim_row_t       stim_rows[$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  bit              no_idle = 1'b0;

  always #4 clk_i = ~clk_i;

  rv32im_instruction_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic decode_t predict_decode(input logic [InstrWidth-1:0] w);
    decode_t             d;
    logic [6:0]          f7;
    logic [4:0]          f5;
    logic [2:0]          f3;
    logic [ImmWidth-1:0] imm_i;
    logic [ImmWidth-1:0] imm;
    logic [OpWidth-1:0]  op;
    f3 = w[14:12];
    f7 = w[31:25];
    f5 = w[24:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    op = OP_INVALID;
    imm = '0;
    case (w[6:0])
      OPC_LUI: begin
        op = OP_LUI;
        imm = {w[31:12], 12'd0};
      end
      OPC_AUIPC: begin
        op = OP_AUIPC;
        imm = {w[31:12], 12'd0};
      end
      OPC_OPIMM: begin
        op = OPIMM_OPS[f3];
        if (op == OP_SRLI) begin
          if (w[31:27] == SHIFT_HI_SRA) op = OP_SRAI;
          else if (w[31:27] != SHIFT_HI_SRL) op = OP_INVALID;
        end
        imm = imm_i;
      end
      OPC_OP: begin
        if (f7 == F7_BASE) op = BASE_OPS[f3];
        else if (f7 == F7_MEXT) op = MEXT_OPS[f3];
        else if (f7 == F7_ALT && BASE_OPS[f3] == OP_ADD) op = OP_SUB;
        else if (f7 == F7_ALT && BASE_OPS[f3] == OP_SRL) op = OP_SRA;
      end
      OPC_FENCE: op = FENCE_OPS[f3];
      OPC_SYSTEM: begin
        if (f3 == F3_PRIV) begin
          case (f7)
            F7_BASE: begin
              if (f5 == F5_ECALL) op = OP_ECALL;
              else if (f5 == F5_EBREAK) op = OP_EBREAK;
              else if (f5 == F5_RET) op = OP_RETNOP;
            end
            F7_SRET: begin
              if (f5 == F5_RET) op = OP_RETNOP;
              else if (f5 == F5_WFI) op = OP_WFI;
            end
            F7_MRET: begin
              if (f5 == F5_RET) op = OP_RETNOP;
            end
            F7_SFENC: op = OP_SFENCE;
            default: ;
          endcase
        end else begin
          op = CSR_OPS[f3];
          imm = {20'd0, w[31:20]};
        end
      end
      OPC_LOAD: begin
        op = LOAD_OPS[f3];
        imm = imm_i;
      end
      OPC_STORE: begin
        op = STORE_OPS[f3];
        imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_JAL: begin
        op = OP_JAL;
        imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        op = OP_JALR;
        imm = imm_i;
      end
      OPC_BRANCH: begin
        op = BRANCH_OPS[f3];
        imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      end
      default: ;
    endcase
    d.word = w;
    d.illegal = (op == OP_INVALID);
    d.fields.operation = d.illegal ? '0 : op;
    d.fields.immediate = d.illegal ? '0 : imm;
    d.fields.dest_index = w[11:7];
    d.fields.src1_index = w[19:15];
    d.fields.src2_index = w[24:20];
    return d;
  endfunction

  // Forces the opcode and function fields of a random word so that it encodes op.
  function automatic logic [InstrWidth-1:0] shape_word(input logic [OpWidth-1:0] op,
                                                       input logic [InstrWidth-1:0] raw);
    logic [InstrWidth-1:0] w;
    int                    k;
    w = raw;
    for (k = 0; k < 8; k++) begin
      if (OPIMM_OPS[k] == op || (OPIMM_OPS[k] == OP_SRLI && op == OP_SRAI)) begin
        w[6:0] = OPC_OPIMM;
        w[14:12] = k[2:0];
      end
      if (BASE_OPS[k] == op) begin
        w[6:0] = OPC_OP;
        w[14:12] = k[2:0];
        w[31:25] = F7_BASE;
      end
      if (MEXT_OPS[k] == op) begin
        w[6:0] = OPC_OP;
        w[14:12] = k[2:0];
        w[31:25] = F7_MEXT;
      end
      if ((BASE_OPS[k] == OP_ADD && op == OP_SUB) || (BASE_OPS[k] == OP_SRL && op == OP_SRA)) begin
        w[6:0] = OPC_OP;
        w[14:12] = k[2:0];
        w[31:25] = F7_ALT;
      end
      if (FENCE_OPS[k] == op) begin
        w[6:0] = OPC_FENCE;
        w[14:12] = k[2:0];
      end
      if (CSR_OPS[k] == op) begin
        w[6:0] = OPC_SYSTEM;
        w[14:12] = k[2:0];
      end
      if (LOAD_OPS[k] == op) begin
        w[6:0] = OPC_LOAD;
        w[14:12] = k[2:0];
      end
      if (STORE_OPS[k] == op) begin
        w[6:0] = OPC_STORE;
        w[14:12] = k[2:0];
      end
      if (BRANCH_OPS[k] == op) begin
        w[6:0] = OPC_BRANCH;
        w[14:12] = k[2:0];
      end
    end
    case (op)
      OP_LUI:   w[6:0] = OPC_LUI;
      OP_AUIPC: w[6:0] = OPC_AUIPC;
      OP_JAL:   w[6:0] = OPC_JAL;
      OP_JALR:  w[6:0] = OPC_JALR;
      OP_SRLI:  w[31:27] = SHIFT_HI_SRL;
      OP_SRAI:  w[31:27] = SHIFT_HI_SRA;
      OP_ECALL: begin
        w[31:20] = {F7_BASE, F5_ECALL};
      end
      OP_EBREAK: begin
        w[31:20] = {F7_BASE, F5_EBREAK};
      end
      OP_WFI: begin
        w[31:20] = {F7_SRET, F5_WFI};
      end
      OP_SFENCE: begin
        w[31:25] = F7_SFENC;
      end
      OP_RETNOP: begin
        case (raw[1:0])
          2'd0:    w[31:20] = {F7_BASE, F5_RET};
          2'd1:    w[31:20] = {F7_SRET, F5_RET};
          default: w[31:20] = {F7_MRET, F5_RET};
        endcase
      end
      default: ;
    endcase
    if (op inside {OP_ECALL, OP_EBREAK, OP_WFI, OP_SFENCE, OP_RETNOP}) begin
      w[6:0] = OPC_SYSTEM;
      w[14:12] = F3_PRIV;
    end
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [InstrWidth-1:0] word,
                                 input logic [31:0] got, input logic [31:0] want);
    if (error_count < PrintLimit) begin
      $display("[%0t] mismatch in %s for word %h: got %h, expected %h",
               $realtime, what, word, got, want);
    end
    error_count++;
  endtask

  task automatic send_word(input decode_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pending_decodes.push_back(want);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= want.word;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic add_row(input logic [InstrWidth-1:0] word, input bit typed,
                         input logic illegal, input logic [OpWidth-1:0] operation,
                         input logic [ImmWidth-1:0] immediate);
    stim_row_t row;
    row.word = word;
    row.typed = typed;
    row.illegal = illegal;
    row.operation = operation;
    row.immediate = immediate;
    stim_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    int unsigned stall;
    forever begin
      burst = $urandom_range(1, 24);
      m_axis_tready_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    decode_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[ResultBits-1:0];
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected beat", '0, m_axis_tdata_o[31:0], '0);
      end else begin
        want = pending_decodes.pop_front();
        if (got.operation !== want.fields.operation)
          report_mismatch("operation", want.word, 32'(got.operation),
                          32'(want.fields.operation));
        if (m_axis_tuser_o !== want.illegal)
          report_mismatch("illegal", want.word, 32'(m_axis_tuser_o), 32'(want.illegal));
        if (got.dest_index !== want.fields.dest_index)
          report_mismatch("dest_index", want.word, 32'(got.dest_index),
                          32'(want.fields.dest_index));
        if (got.src1_index !== want.fields.src1_index)
          report_mismatch("src1_index", want.word, 32'(got.src1_index),
                          32'(want.fields.src1_index));
        if (got.src2_index !== want.fields.src2_index)
          report_mismatch("src2_index", want.word, 32'(got.src2_index),
                          32'(want.fields.src2_index));
        if (got.immediate !== want.fields.immediate)
          report_mismatch("immediate", want.word, got.immediate, want.fields.immediate);
      end
    end
  end

  initial begin
    decode_t               want;
    logic [InstrWidth-1:0] w;
    logic [OpWidth-1:0]    op;
    int unsigned           r;
    int unsigned           i;

    // Words of the form (word, typed, illegal, operation, immediate); untyped rows are predicted.
    add_row(32'h0000_0000, 1'b1, 1'b1, '0, '0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, '0, '0);
    add_row(32'hFFFF_FFB7, 1'b1, 1'b0, OP_LUI, 32'hFFFF_F000);
    add_row(32'h8000_0017, 1'b1, 1'b0, OP_AUIPC, 32'h8000_0000);
    add_row(32'hFFF0_0013, 1'b1, 1'b0, OP_ADDI, 32'hFFFF_FFFF);
    add_row(32'h7FF0_0013, 1'b1, 1'b0, OP_ADDI, 32'h0000_07FF);
    add_row(32'hFE00_1013, 1'b0, 1'b0, '0, '0);
    add_row(32'h4000_5013, 1'b0, 1'b0, '0, '0);
    add_row(32'h2000_5013, 1'b1, 1'b1, '0, '0);
    add_row(32'h4000_0033, 1'b0, 1'b0, '0, '0);
    add_row(32'h4000_1033, 1'b1, 1'b1, '0, '0);
    add_row(32'h0200_7033, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_100F, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_200F, 1'b1, 1'b1, '0, '0);
    add_row(32'h0010_0073, 1'b0, 1'b0, '0, '0);
    add_row(32'h3020_0073, 1'b0, 1'b0, '0, '0);
    add_row(32'h1050_0073, 1'b0, 1'b0, '0, '0);
    add_row(32'h1200_0073, 1'b0, 1'b0, '0, '0);
    add_row(32'h0030_0073, 1'b1, 1'b1, '0, '0);
    add_row(32'h0000_4073, 1'b1, 1'b1, '0, '0);
    add_row(32'hFFF0_1073, 1'b1, 1'b0, OP_CSRRW, 32'h0000_0FFF);
    add_row(32'hFFFF_F06F, 1'b1, 1'b0, OP_JAL, 32'hFFFF_FFFE);
    add_row(32'h0000_70E7, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_2063, 1'b1, 1'b1, '0, '0);
    add_row(32'hFE00_2FA3, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_3003, 1'b1, 1'b1, '0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[n]) begin
      if (stim_rows[n].typed) begin
        want.word = stim_rows[n].word;
        want.illegal = stim_rows[n].illegal;
        want.fields.operation = stim_rows[n].operation;
        want.fields.immediate = stim_rows[n].immediate;
        want.fields.dest_index = stim_rows[n].word[11:7];
        want.fields.src1_index = stim_rows[n].word[19:15];
        want.fields.src2_index = stim_rows[n].word[24:20];
      end else begin
        want = predict_decode(stim_rows[n].word);
      end
      send_word(want);
    end

    // Mostly well-formed words of every operation, mixed with near misses and raw noise.
    for (i = 0; i < RandomWords; i++) begin
      no_idle = ((i / 60) % 3 == 1);
      r = $urandom_range(0, 99);
      op = OpWidth'($urandom_range(0, OP_RETNOP));
      w = shape_word(op, $urandom);
      if (r >= 90) w = $urandom;
      else if (r >= 75) w = w ^ (32'h1 << $urandom_range(0, 31));
      send_word(predict_decode(w));
    end
    no_idle = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
